FILE: rtl/mhd_pkg.sv
`default_nettype none
package mhd_pkg;

  // field widths of the request and result items
  localparam int HANDLE_W = 16;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 5;

  // count field of the cell command, wide enough for the largest depth (256)
  localparam int CNT_W = 9;

  // request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP_OLD  = 2'd1,
    ACT_POP_NEW  = 2'd2,
    ACT_REMOVE   = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                go;
    action_t             action;
    logic [HANDLE_W-1:0] handle;
    logic [CNT_W-1:0]    count;
    logic                found;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/mhd_cell.sv
`default_nettype none
module mhd_cell #(
  parameter int INDEX = 0
) (
  input  wire                           clk,
  input  wire  mhd_pkg::cell_cmd_t      cmd,
  input  wire  [mhd_pkg::HANDLE_W-1:0]  up_data,
  input  wire                           match_in,
  input  wire  [mhd_pkg::HANDLE_W-1:0]  pick_in,
  output logic [mhd_pkg::HANDLE_W-1:0]  data,
  output logic                          match_out,
  output logic [mhd_pkg::HANDLE_W-1:0]  pick_out
);
  import mhd_pkg::*;

  localparam logic [CNT_W-1:0] IDX     = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_ONE = CNT_W'(INDEX + 1);

  logic occupied;
  logic is_last;
  logic is_free_slot;
  logic hit;
  logic load;
  logic shift;

  // position of this cell relative to the fill count
  assign occupied     = IDX < cmd.count;
  assign is_last      = IDX_ONE == cmd.count;
  assign is_free_slot = IDX == cmd.count;
  assign hit          = occupied && (data == cmd.handle);

  // match-above chain runs from the newest cell down to the oldest
  assign match_out = match_in | hit;

  // newest entry travels down the chain to the oldest end
  assign pick_out = pick_in | (is_last ? data : '0);

  // cell write decision
  always_comb begin
    load  = 1'b0;
    shift = 1'b0;
    if (cmd.go) begin
      case (cmd.action)
        ACT_PUSH:    load  = is_free_slot;
        ACT_POP_OLD: shift = cmd.count != '0;
        ACT_POP_NEW: shift = 1'b0;
        ACT_REMOVE:  shift = cmd.found && !match_in;
        default:     shift = 1'b0;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (load) begin
      data <= cmd.handle;
    end else if (shift) begin
      data <= up_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/message_handle_deque_with_removal.sv
// Message handle deque with removal by search. Each request on the slave
// stream asks to push a 16-bit handle at the newest end, pop the oldest
// handle, pop the newest handle, or remove a named handle from wherever it
// sits (the newest copy when duplicates are held); the others keep their
// order. Every request gives exactly one result: the handle taken out (zero
// when none), a status (done, empty or not found, full push refused) and
// the count held afterwards. Handles live in a chain of DEPTH cells, one
// handle per cell, oldest in cell zero; a removal or oldest pop shifts the
// upper cells down one place, and a match flag ripples from the newest cell
// toward the oldest. A request is accepted in IDLE, then in EXEC updates the
// chain and loads the result register. A new request is taken while a result
// waits; the update then holds until the result register frees up. No
// clearing pass is needed after reset.
`default_nettype none
module message_handle_deque_with_removal #(
  parameter int DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  // slave request: [1:0] action, [17:2] handle, [23:18] zero
  input  wire  [23:0] s_tdata,
  input  wire         s_tvalid,
  output logic        s_tready,
  // master result: [15:0] out_handle, [17:16] status, [22:18] held, [23] zero
  output logic [23:0] m_tdata,
  output logic        m_tvalid,
  input  wire         m_tready
);
  import mhd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t              state;
  action_t             req_action;
  logic [HANDLE_W-1:0] req_handle;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;

  logic [HANDLE_W-1:0] out_handle;
  status_t             status;
  logic [HELD_W-1:0]   held;
  logic [HANDLE_W-1:0] taken_next;
  status_t             status_next;

  logic                go;
  logic                found;
  cell_cmd_t           cmd;

  logic [HANDLE_W-1:0] data_w  [DEPTH+1];
  logic [HANDLE_W-1:0] pick_w  [DEPTH+1];
  logic                match_w [DEPTH+1];

  // handshake
  assign s_tready = state == IDLE;
  assign go       = (state == EXEC) && (!m_tvalid || m_tready);
  assign m_tdata  = {1'b0, held, status, out_handle};

  // broadcast command for the cell chain
  assign found = match_w[0];
  always_comb begin
    cmd.go     = go;
    cmd.action = req_action;
    cmd.handle = req_handle;
    cmd.count  = CNT_W'(count);
    cmd.found  = found;
  end

  // chain ends
  assign data_w[DEPTH]  = '0;
  assign pick_w[DEPTH]  = '0;
  assign match_w[DEPTH] = 1'b0;

  // cell chain, newest end at the top
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mhd_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .up_data  (data_w[i+1]),
      .match_in (match_w[i+1]),
      .pick_in  (pick_w[i+1]),
      .data     (data_w[i]),
      .match_out(match_w[i]),
      .pick_out (pick_w[i])
    );
  end

  // result of the pending request
  always_comb begin
    count_next  = count;
    taken_next  = '0;
    status_next = ST_DONE;
    case (req_action)
      ACT_PUSH: begin
        if (count == FULL_COUNT) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      ACT_POP_OLD: begin
        if (count == '0) begin
          status_next = ST_NONE;
        end else begin
          taken_next = data_w[0];
          count_next = count - CW'(1);
        end
      end
      ACT_POP_NEW: begin
        if (count == '0) begin
          status_next = ST_NONE;
        end else begin
          taken_next = pick_w[0];
          count_next = count - CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          taken_next = req_handle;
          count_next = count - CW'(1);
        end else begin
          status_next = ST_NONE;
        end
      end
      default: status_next = ST_NONE;
    endcase
  end

  // control state, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result valid: set on an update, cleared once taken
      if (go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            req_action <= action_t'(s_tdata[ACTION_W-1:0]);
            req_handle <= s_tdata[ACTION_W +: HANDLE_W];
            state      <= EXEC;
          end
        end
        EXEC: begin
          if (go) begin
            count      <= count_next;
            out_handle <= taken_next;
            status     <= status_next;
            held       <= HELD_W'(count_next);
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // fill count stays within the chain
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("fill count beyond depth");

  // a refused push reports a full store
  a_full_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_FULL |-> held == HELD_W'(DEPTH))
    else $error("full status with store not full");

  // nothing taken out reports a zero handle
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_NONE || status == ST_FULL) |-> out_handle == '0)
    else $error("handle reported without removal");

  // an accepted request is worked before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while one is pending");

  // the count moves only when the chain is updated
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(count))
    else $error("fill count changed without an update");

endmodule
`default_nettype wire
